// File: src/saabb_pkg.sv
// Shared types and default constants for the swept box time-of-impact block.
// Used by saabb_alu and swept_aabb_time_of_impact; depends on nothing else.
package saabb_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_AXES        = 3;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP1,
    S_PREP2,
    S_PREP3,
    S_DIV,
    S_RECIP,
    S_MUL,
    S_PROD,
    S_MERGE,
    S_AXIS_END,
    S_FINISH
  } saabb_state_t;

  // Operations of the shared add/subtract step unit.
  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_DIV,
    ALU_MUL
  } saabb_op_t;

  typedef struct packed {
    saabb_op_t op;
    logic      bit_in;
  } saabb_ctrl_t;

endpackage

// File: src/saabb_alu.sv
// Shared step unit: one restoring-division step or one shift-add multiply step per cycle.
// Depends on saabb_pkg for the operation codes and the control struct.
module saabb_alu #(
  parameter int CW = 32,
  parameter int LW = 33
) (
  input  logic               clk,
  input  saabb_pkg::saabb_ctrl_t ctrl,
  input  logic [CW-2:0]      opnd,
  input  logic [LW-1:0]      load_value,
  output logic [CW-1:0]      hi,
  output logic [LW-1:0]      lo
);
  import saabb_pkg::*;

  logic [CW-1:0] hi_next;
  logic [LW-1:0] lo_next;
  logic [CW-1:0] trial;
  logic [CW:0]   diff;
  logic [CW-1:0] sum;

  always_comb begin
    trial   = {hi[CW-2:0], ctrl.bit_in};
    diff    = {1'b0, trial} - {2'b00, opnd};
    sum     = hi + (lo[0] ? {1'b0, opnd} : '0);
    hi_next = hi;
    lo_next = lo;
    unique case (ctrl.op)
      ALU_HOLD: begin
        hi_next = hi;
        lo_next = lo;
      end
      ALU_LOAD: begin
        hi_next = '0;
        lo_next = load_value;
      end
      ALU_DIV: begin
        // The remainder lives in hi, quotient bits shift into lo.
        if (!diff[CW]) begin
          hi_next = diff[CW-1:0];
          lo_next = {lo[LW-2:0], 1'b1};
        end else begin
          hi_next = trial;
          lo_next = {lo[LW-2:0], 1'b0};
        end
      end
      ALU_MUL: begin
        // Multiplier bits leave lo at the bottom, product bits enter at the top.
        hi_next = {1'b0, sum[CW-1:1]};
        lo_next = {sum[0], lo[LW-1:1]};
      end
      default: begin
        hi_next = hi;
        lo_next = lo;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hi <= hi_next;
    lo <= lo_next;
  end

endmodule

// File: src/swept_aabb_time_of_impact.sv
// Top level of the swept box-versus-box time-of-impact block (slab test).
// Depends on saabb_pkg and instantiates the shared step unit saabb_alu.
//
// Usage: each input word carries one axis of both boxes (corner, extent and
// motion over the frame, signed fixed point) and a last_axis mark. A query is
// up to AXES words; the word marked last, or the AXES-th word, ends it and
// produces exactly one result word with collided and impact_time.
// Both channels use valid/ready. in_ready is high only while the sequencer is
// idle, so one axis word is processed at a time.
// Sequence: an axis with zero relative velocity passes through the prep states
// and the axis-end state before in_ready returns. A moving axis runs a
// 2*FRAC_BITS+1 step reciprocal and two COORD_WIDTH-1 step multiplies through
// the one shared step unit. The word that ends a query also passes through the
// finish state, in which the result register is loaded.
// The result register holds its word until out_ready; while it waits the block
// still takes and processes the axes of the next query, and only stops before
// its own result if the previous one has not been taken yet.
// Reset clears the sequencer, the result valid flag and the running entry and
// exit times and flags; no clearing pass is needed.
module swept_aabb_time_of_impact #(
  parameter int COORD_WIDTH = saabb_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = saabb_pkg::DEF_FRAC_BITS,
  parameter int AXES        = saabb_pkg::DEF_AXES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] a_position,
  input  logic        [COORD_WIDTH-2:0] a_size,
  input  logic signed [COORD_WIDTH-1:0] a_velocity,
  input  logic signed [COORD_WIDTH-1:0] b_position,
  input  logic        [COORD_WIDTH-2:0] b_size,
  input  logic signed [COORD_WIDTH-1:0] b_velocity,
  input  logic                          last_axis,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          collided,
  output logic        [FRAC_BITS:0]     impact_time
);
  import saabb_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int QW = 2 * F + 1;                       // reciprocal quotient bits
  localparam int LW = (QW > CW - 1) ? QW : CW - 1;     // low word of the step unit
  localparam int PW = 2 * CW - 2;                      // full product width
  localparam int SW = $clog2(LW);                      // step counter width
  localparam int AW = $clog2(AXES + 1);
  localparam int TW = ((CW > F + 1) ? CW : F + 1) + 1; // width for the 1.0 compare

  localparam logic        [CW-2:0] LIM_M  = {(CW-1){1'b1}};
  localparam logic signed [CW-1:0] LIM_S  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] NLIM_S = -LIM_S;
  localparam logic signed [CW:0]   LIM_W  = {2'b00, {(CW-1){1'b1}}};
  localparam logic signed [CW:0]   NLIM_W = -LIM_W;
  localparam logic signed [TW-1:0] ONE_W  = {{(TW-1){1'b0}}, 1'b1} << F;

  // Symmetric saturation of a one-bit-grown sum back to the coordinate range.
  function automatic logic signed [CW-1:0] sat_w(input logic signed [CW:0] x);
    logic signed [CW-1:0] r;
    if (x > LIM_W) r = LIM_S;
    else if (x < NLIM_W) r = NLIM_S;
    else r = x[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [CW:0] wide_s(input logic signed [CW-1:0] v);
    return (CW+1)'(v);
  endfunction

  function automatic logic signed [CW:0] wide_u(input logic [CW-2:0] v);
    return {2'b00, v};
  endfunction

  // Magnitude of a value already saturated to [-LIM, LIM].
  function automatic logic [CW-2:0] mag_of(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] n;
    n = -v;
    return v[CW-1] ? n[CW-2:0] : v[CW-2:0];
  endfunction

  saabb_state_t state, state_next;

  // Latched axis word.
  logic signed [CW-1:0] pos_a, vel_a, pos_b, vel_b;
  logic        [CW-2:0] size_a, size_b;
  logic                 last_r;

  // Per-axis intermediate values.
  logic signed [CW-1:0] rel_vel, exp_pos, exp_size, far_edge, b_far, a_far;
  logic signed [CW-1:0] dist_near, dist_far;
  logic        [CW-2:0] rel_mag, inv_mag, mul_mag;
  logic                 inv_neg, mul_neg, mul_second;
  logic signed [CW-1:0] t_first, t_second;
  logic        [SW-1:0] step;

  // Running query state.
  logic signed [CW-1:0] entry_time, exit_time;
  logic                 axis_rejected, all_still, strict_overlap;
  logic        [AW-1:0] axis_count;

  // Shared step unit.
  saabb_ctrl_t   alu_ctrl;
  logic [CW-2:0] alu_opnd;
  logic [LW-1:0] alu_load;
  logic [CW-1:0] alu_hi;
  logic [LW-1:0] alu_lo;

  saabb_alu #(
    .CW(CW),
    .LW(LW)
  ) u_alu (
    .clk       (clk),
    .ctrl      (alu_ctrl),
    .opnd      (alu_opnd),
    .load_value(alu_load),
    .hi        (alu_hi),
    .lo        (alu_lo)
  );

  // Reciprocal result, clamped to the coordinate range.
  logic          q_sat;
  logic [CW-2:0] recip_mag;
  // Product shifted down by the fraction bits, clamped, then signed.
  logic [PW-1:0]        product, prod_shift;
  logic                 prod_sat;
  logic        [CW-2:0] prod_mag;
  logic signed [CW-1:0] prod_t;
  logic signed [CW-1:0] t_low, t_high;
  logic                 query_end, out_free, hit_moving;
  logic signed [TW-1:0] entry_ext;

  always_comb begin
    q_sat      = alu_lo > LW'(LIM_M);
    recip_mag  = q_sat ? LIM_M : alu_lo[CW-2:0];
    product    = {alu_hi[CW-2:0], alu_lo[LW-1 -: CW-1]};
    prod_shift = product >> F;
    prod_sat   = prod_shift > PW'(LIM_M);
    prod_mag   = prod_sat ? LIM_M : prod_shift[CW-2:0];
    prod_t     = mul_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
    t_low      = (t_first > t_second) ? t_second : t_first;
    t_high     = (t_first > t_second) ? t_first : t_second;
    query_end  = last_r || ((AW+1)'(axis_count) + 1'b1 >= (AW+1)'(AXES));
    out_free   = !out_valid || out_ready;
    entry_ext  = TW'(entry_time);
    hit_moving = !axis_rejected && (entry_time < exit_time) &&
                 !entry_time[CW-1] && (entry_ext <= ONE_W);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    alu_ctrl.op     = ALU_HOLD;
    alu_ctrl.bit_in = 1'b0;
    alu_opnd        = mul_mag;
    alu_load        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_PREP1;
      end
      S_PREP1: state_next = S_PREP2;
      S_PREP2: state_next = S_PREP3;
      S_PREP3: begin
        if (rel_vel == '0) begin
          state_next = S_AXIS_END;
        end else begin
          alu_ctrl.op = ALU_LOAD;
          state_next  = S_DIV;
        end
      end
      S_DIV: begin
        // The dividend is a single one at bit 2*F, fed in on the first step.
        alu_ctrl.op     = ALU_DIV;
        alu_ctrl.bit_in = (step == '0);
        alu_opnd        = rel_mag;
        if (step == SW'(QW - 1)) state_next = S_RECIP;
      end
      S_RECIP: begin
        alu_ctrl.op = ALU_LOAD;
        alu_load    = LW'(recip_mag);
        state_next  = S_MUL;
      end
      S_MUL: begin
        alu_ctrl.op = ALU_MUL;
        if (step == SW'(CW - 2)) state_next = S_PROD;
      end
      S_PROD: begin
        if (!mul_second) begin
          alu_ctrl.op = ALU_LOAD;
          alu_load    = LW'(inv_mag);
          state_next  = S_MUL;
        end else begin
          state_next = S_MERGE;
        end
      end
      S_MERGE:    state_next = S_AXIS_END;
      S_AXIS_END: state_next = query_end ? S_FINISH : S_IDLE;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        pos_a  <= a_position;
        size_a <= a_size;
        vel_a  <= a_velocity;
        pos_b  <= b_position;
        size_b <= b_size;
        vel_b  <= b_velocity;
        last_r <= last_axis;
      end
      S_PREP1: begin
        // B is widened by A's extent so A shrinks to its minimum corner.
        rel_vel  <= sat_w(wide_s(vel_a) - wide_s(vel_b));
        exp_pos  <= sat_w(wide_s(pos_b) - wide_u(size_a));
        exp_size <= sat_w(wide_u(size_b) + wide_u(size_a));
        b_far    <= sat_w(wide_s(pos_b) + wide_u(size_b));
        a_far    <= sat_w(wide_s(pos_a) + wide_u(size_a));
      end
      S_PREP2: begin
        far_edge <= sat_w(wide_s(exp_pos) + wide_s(exp_size));
      end
      S_PREP3: begin
        dist_near <= sat_w(wide_s(exp_pos) - wide_s(pos_a));
        dist_far  <= sat_w(wide_s(far_edge) - wide_s(pos_a));
        rel_mag   <= mag_of(rel_vel);
        inv_neg   <= rel_vel[CW-1];
        step      <= '0;
      end
      S_DIV: begin
        step <= step + 1'b1;
      end
      S_RECIP: begin
        inv_mag    <= recip_mag;
        mul_mag    <= mag_of(dist_near);
        mul_neg    <= dist_near[CW-1] ^ inv_neg;
        mul_second <= 1'b0;
        step       <= '0;
      end
      S_MUL: begin
        step <= step + 1'b1;
      end
      S_PROD: begin
        if (!mul_second) begin
          t_first    <= prod_t;
          mul_mag    <= mag_of(dist_far);
          mul_neg    <= dist_far[CW-1] ^ inv_neg;
          mul_second <= 1'b1;
          step       <= '0;
        end else begin
          t_second <= prod_t;
        end
      end
      default: begin
      end
    endcase
  end

  // Running query state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_time     <= NLIM_S;
      exit_time      <= LIM_S;
      axis_rejected  <= 1'b0;
      all_still      <= 1'b1;
      strict_overlap <= 1'b1;
      axis_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_PREP2: begin
          if (!(pos_a < b_far && a_far > pos_b)) strict_overlap <= 1'b0;
        end
        S_PREP3: begin
          // A still axis must already hold A's corner inside the widened slab.
          if (rel_vel == '0) begin
            if (pos_a < exp_pos || pos_a > far_edge) axis_rejected <= 1'b1;
          end else begin
            all_still <= 1'b0;
          end
        end
        S_MERGE: begin
          if (t_low > entry_time) entry_time <= t_low;
          if (t_high < exit_time) exit_time <= t_high;
        end
        S_AXIS_END: begin
          if (!query_end) axis_count <= axis_count + 1'b1;
        end
        S_FINISH: begin
          if (out_free) begin
            entry_time     <= NLIM_S;
            exit_time      <= LIM_S;
            axis_rejected  <= 1'b0;
            all_still      <= 1'b1;
            strict_overlap <= 1'b1;
            axis_count     <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result payload; a query with no moving axis reports time zero.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      collided    <= all_still ? strict_overlap : hit_moving;
      impact_time <= (!all_still && hit_moving) ? entry_ext[F:0] : '0;
    end
  end

  // A word is never taken twice in a row; processing always follows.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && state == S_PREP1)
    else $error("input taken while an axis is still in work");

  // Between queries the running flags are back at their reset values.
  a_clean_start: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && axis_count == '0 |->
      all_still && strict_overlap && !axis_rejected &&
      entry_time == NLIM_S && exit_time == LIM_S)
    else $error("query state not cleared before a new query");

  // The axis counter never reaches the axis count.
  a_axis_bound: assert property (@(posedge clk) disable iff (rst)
    (AW+1)'(axis_count) < (AW+1)'(AXES))
    else $error("axis counter out of range");

  // A free result register is loaded on the cycle the query finishes.
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && out_free |=> out_valid && state == S_IDLE)
    else $error("finished query not delivered");

  // A reported time of impact always comes with a collision.
  a_time_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && out_free && (all_still || !hit_moving) |=>
      impact_time == '0)
    else $error("nonzero time without a collision");

endmodule

// File: verif/tb.sv
// Self-checking testbench for swept_aabb_time_of_impact (swept box slab test).
// Holds its own time-of-impact predictor and result store in a small class.
// Depends on saabb_pkg and the block's RTL only.

localparam int COORD_W    = saabb_pkg::DEF_COORD_WIDTH;
localparam int FRAC_W     = saabb_pkg::DEF_FRAC_BITS;
localparam int AXIS_COUNT = saabb_pkg::DEF_AXES;
localparam longint TOI_LIM = (longint'(1) <<< (COORD_W - 1)) - 1;
localparam longint TOI_ONE = longint'(1) <<< FRAC_W;

typedef struct {
  logic signed [COORD_W-1:0] a_position;
  logic        [COORD_W-2:0] a_size;
  logic signed [COORD_W-1:0] a_velocity;
  logic signed [COORD_W-1:0] b_position;
  logic        [COORD_W-2:0] b_size;
  logic signed [COORD_W-1:0] b_velocity;
  logic                      last_axis;
} axis_word_t;

typedef struct {
  logic              collided;
  logic [FRAC_W:0]   impact_time;
} impact_word_t;

class impact_predictor;
  longint entry_t;
  longint exit_t;
  bit     rejected;
  bit     still_all;
  bit     overlap_strict;
  int     axes_seen;
  impact_word_t expected_impacts[$];
  int     failures;

  function new();
    restart();
    failures = 0;
  endfunction

  function void restart();
    entry_t        = -TOI_LIM;
    exit_t         = TOI_LIM;
    rejected       = 0;
    still_all      = 1;
    overlap_strict = 1;
    axes_seen      = 0;
  endfunction

  function longint clamp(longint x);
    if (x > TOI_LIM) return TOI_LIM;
    if (x < -TOI_LIM) return -TOI_LIM;
    return x;
  endfunction

  // Truncating reciprocal of a nonzero fixed-point value.
  function longint recip_q(longint d);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = (longint'(1) <<< (2 * FRAC_W)) / mag;
    if (q > TOI_LIM) q = TOI_LIM;
    return (d < 0) ? -q : q;
  endfunction

  // Truncating fixed-point multiply on magnitudes, saturated.
  function longint mul_q(longint a, longint b);
    bit     neg;
    longint ua;
    longint ub;
    longint m;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    m   = (ua * ub) >>> FRAC_W;
    if (m > TOI_LIM) m = TOI_LIM;
    return neg ? -m : m;
  endfunction

  function void note_axis(axis_word_t w);
    longint a_pos, a_ext, a_vel, b_pos, b_ext, b_vel;
    longint rel_v, slab_lo, slab_w, slab_hi, b_hi, a_hi;
    longint inv, t_near, t_far, t_swap, toi;
    bit hit;
    impact_word_t r;
    a_pos = w.a_position;
    a_ext = w.a_size;
    a_vel = w.a_velocity;
    b_pos = w.b_position;
    b_ext = w.b_size;
    b_vel = w.b_velocity;
    rel_v   = clamp(a_vel - b_vel);
    slab_lo = clamp(b_pos - a_ext);
    slab_w  = clamp(b_ext + a_ext);
    slab_hi = clamp(slab_lo + slab_w);
    b_hi    = clamp(b_pos + b_ext);
    a_hi    = clamp(a_pos + a_ext);
    if (!(a_pos < b_hi && a_hi > b_pos)) overlap_strict = 0;
    if (rel_v == 0) begin
      if (a_pos < slab_lo || a_pos > slab_hi) rejected = 1;
    end else begin
      inv    = recip_q(rel_v);
      t_near = mul_q(clamp(slab_lo - a_pos), inv);
      t_far  = mul_q(clamp(slab_hi - a_pos), inv);
      still_all = 0;
      if (t_near > t_far) begin
        t_swap = t_near;
        t_near = t_far;
        t_far  = t_swap;
      end
      if (t_near > entry_t) entry_t = t_near;
      if (t_far < exit_t) exit_t = t_far;
    end
    axes_seen++;
    if (w.last_axis || axes_seen >= AXIS_COUNT) begin
      toi = 0;
      if (still_all) begin
        hit = overlap_strict;
      end else begin
        hit = !rejected && entry_t < exit_t && entry_t >= 0 && entry_t <= TOI_ONE;
        if (hit) toi = entry_t;
      end
      r.collided    = hit;
      r.impact_time = toi[FRAC_W:0];
      expected_impacts.push_back(r);
      restart();
    end
  endfunction

  function void check_impact(logic c, logic [FRAC_W:0] t);
    impact_word_t e;
    if (expected_impacts.size() == 0) begin
      $error("result word with no query pending: collided=%0b impact_time=%0d", c, t);
      failures++;
      return;
    end
    e = expected_impacts.pop_front();
    if (c !== e.collided) begin
      $error("collided: expected %0b, actual %0b", e.collided, c);
      failures++;
    end
    if (t !== e.impact_time) begin
      $error("impact_time: expected %0d, actual %0d", e.impact_time, t);
      failures++;
    end
  endfunction

  function int outstanding();
    return expected_impacts.size();
  endfunction
endclass

module tb;
  // One unit in Q16.16 and the coordinate extremes used by the directed part.
  localparam int Q = 1 << FRAC_W;
  localparam logic signed [COORD_W-1:0] MINP = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] MAXP = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-2:0] MAXS = {(COORD_W-1){1'b1}};
  // The stall limit is many times the longest correct gap between two accepted
  // words on either channel.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 850;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic signed [COORD_W-1:0] a_position = '0;
  logic        [COORD_W-2:0] a_size = '0;
  logic signed [COORD_W-1:0] a_velocity = '0;
  logic signed [COORD_W-1:0] b_position = '0;
  logic        [COORD_W-2:0] b_size = '0;
  logic signed [COORD_W-1:0] b_velocity = '0;
  logic last_axis = 0;
  logic out_ready = 0;
  logic in_ready;
  logic out_valid;
  logic collided;
  logic [FRAC_W:0] impact_time;

  // Idle percentages of the sender and the receiver; the main sequence moves
  // them between phases, and sets both to zero for the final stretch.
  int tx_pct = 10;
  int rx_pct = 10;
  int rx_hold = 0;
  int idle_cycles;
  int items_sent = 0;

  impact_predictor pred = new();

  always #5 clk = ~clk;

  swept_aabb_time_of_impact uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .a_position  (a_position),
    .a_size      (a_size),
    .a_velocity  (a_velocity),
    .b_position  (b_position),
    .b_size      (b_size),
    .b_velocity  (b_velocity),
    .last_axis   (last_axis),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .collided    (collided),
    .impact_time (impact_time)
  );

  // Every result word taken at an edge is checked against the oldest
  // predicted word. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) pred.check_impact(collided, impact_time);
  end

  // The receiver drops ready in random bursts whose length is drawn into rx_hold.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= (rx_hold == 0);
    end else if ($urandom_range(99) < rx_pct) begin
      rx_hold = $urandom_range(1, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // The watchdog ends the run when neither channel moves a word for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Fields arrive as plain integers and are cut to their port widths here.
  function automatic axis_word_t make_axis(
    longint ap, longint asz, longint av,
    longint bp, longint bsz, longint bv,
    int last);
    axis_word_t w;
    w.a_position = COORD_W'(ap);
    w.a_size     = (COORD_W-1)'(asz);
    w.a_velocity = COORD_W'(av);
    w.b_position = COORD_W'(bp);
    w.b_size     = (COORD_W-1)'(bsz);
    w.b_velocity = COORD_W'(bv);
    w.last_axis  = last[0];
    return w;
  endfunction

  // A near axis keeps both boxes within a few units of each other so that
  // hits, misses and grazes all occur; a noisy axis takes any bit pattern.
  function automatic axis_word_t rand_axis(bit noisy, logic last);
    axis_word_t w;
    int sel;
    if (noisy) begin
      w = make_axis($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    last);
    end else begin
      w.a_position = int'($urandom_range(0, 16 * Q)) - 8 * Q;
      w.b_position = int'($urandom_range(0, 16 * Q)) - 8 * Q;
      w.a_size     = (COORD_W-1)'($urandom_range(0, 4 * Q));
      w.b_size     = (COORD_W-1)'($urandom_range(0, 4 * Q));
      w.b_velocity = int'($urandom_range(0, 32 * Q)) - 16 * Q;
      w.last_axis  = last;
      sel = $urandom_range(0, 4);
      case (sel)
        0: begin
          w.a_velocity = '0;
          w.b_velocity = '0;
        end
        1: w.a_velocity = w.b_velocity;
        2: w.a_velocity = w.b_velocity + int'($urandom_range(0, 16)) - 8;
        default: w.a_velocity = int'($urandom_range(0, 32 * Q)) - 16 * Q;
      endcase
    end
    return w;
  endfunction

  // Presents one axis word, maybe after a short gap, and holds it until the
  // block takes it. Called right after a rising edge and returns at one.
  task automatic send_axis(input axis_word_t w);
    int gap;
    if ($urandom_range(99) < tx_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    a_position <= w.a_position;
    a_size     <= w.a_size;
    a_velocity <= w.a_velocity;
    b_position <= w.b_position;
    b_size     <= w.b_size;
    b_velocity <= w.b_velocity;
    last_axis  <= w.last_axis;
    do @(posedge clk); while (in_ready !== 1'b1);
    pred.note_axis(w);
    items_sent++;
  endtask

  // The sender holds off until every predicted result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pred.outstanding() != 0);
  endtask

  initial begin
    int target;
    int n;
    int noise_pct;
    int phase;
    int queries;
    bit unmarked;
    queries = 0;
    phase = -1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Still on every axis with a strict overlap: a hit at time zero.
    send_axis(make_axis(0, 2 * Q, 0, Q, 2 * Q, 0, 0));
    send_axis(make_axis(0, 2 * Q, 0, Q, 2 * Q, 0, 0));
    send_axis(make_axis(0, 2 * Q, 0, Q, 2 * Q, 0, 1));
    // Equal nonzero velocities count as still; faces that only touch miss.
    send_axis(make_axis(0, Q, 3 * Q, Q, Q, 3 * Q, 0));
    send_axis(make_axis(0, 2 * Q, 0, Q, 2 * Q, 0, 0));
    send_axis(make_axis(0, 2 * Q, 0, Q, 2 * Q, 0, 1));
    // One moving axis closing in, entry at a quarter of the frame.
    send_axis(make_axis(0, Q, 4 * Q, 2 * Q, Q, 0, 0));
    send_axis(make_axis(0, 2 * Q, 0, Q, 2 * Q, 0, 0));
    send_axis(make_axis(0, 2 * Q, 0, Q, 2 * Q, 0, 1));
    // Still axes whose corner sits exactly on either edge of the expanded slab.
    send_axis(make_axis(0, Q, 4 * Q, 2 * Q, Q, 0, 0));
    send_axis(make_axis(-Q, Q, 0, 0, Q, 0, 0));
    send_axis(make_axis(Q, Q, 0, -Q, 2 * Q, 0, 1));
    // A still axis outside the slab rejects the moving one.
    send_axis(make_axis(0, Q, 4 * Q, 2 * Q, Q, 0, 0));
    send_axis(make_axis(5 * Q, Q, 0, 0, Q, 0, 0));
    send_axis(make_axis(0, 2 * Q, 0, Q, 2 * Q, 0, 1));
    // One-axis queries: negative velocity, entry past the frame, entry before
    // the frame, and entry at exactly 1.0.
    send_axis(make_axis(4 * Q, Q, -4 * Q, 0, Q, 0, 1));
    send_axis(make_axis(0, Q, Q, 10 * Q, Q, 0, 1));
    send_axis(make_axis(0, 2 * Q, -Q, Q, 2 * Q, 0, 1));
    send_axis(make_axis(0, Q, Q, 2 * Q, Q, 0, 1));
    // Field extremes with saturation everywhere, and no end mark at all.
    send_axis(make_axis(MINP, MAXS, MAXP, MAXP, MAXS, MINP, 0));
    send_axis(make_axis(MAXP, 0, MINP, MINP, 0, MAXP, 0));
    send_axis(make_axis(0, MAXS, 0, 0, MAXS, 0, 0));
    // Two-axis query; the first axis crawls by one LSB so its reciprocal saturates.
    send_axis(make_axis(0, Q, 1, 0, Q, 0, 0));
    send_axis(make_axis(0, Q, 4 * Q, 2 * Q, Q, 0, 1));
    wait_drained();

    // Random queries of one to three axes, now and then without an end mark.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (items_sent >= target - 100) begin
        tx_pct = 0;
        rx_pct = 0;
      end else if (items_sent / 64 != phase) begin
        phase = items_sent / 64;
        case ($urandom_range(0, 2))
          0: tx_pct = 0;
          1: tx_pct = 15;
          default: tx_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: rx_pct = 0;
          1: rx_pct = 15;
          default: rx_pct = 40;
        endcase
      end
      noise_pct = ($urandom_range(0, 3) == 0) ? 60 : 10;
      n = $urandom_range(1, 3);
      unmarked = (n == 3) && ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
        send_axis(rand_axis($urandom_range(99) < noise_pct, (i == n - 1) && !unmarked));
      end
      queries++;
      // The final stretch runs without any pause of the sender.
      if (queries % 60 == 0 && items_sent < target - 100) wait_drained();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pred.outstanding() != 0);
    // Watch a while longer for any stray result word.
    repeat (250) @(posedge clk);
    if (pred.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
